/* rtl/core/ps2md_pkg.sv */
package ps2md_pkg;

    // default accumulator width
    localparam int ACC_WIDTH_DEF = 16;

    // command queue depth and pointer width
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // beats in one event record
    localparam int          EVENT_BEATS = 5;
    localparam int          BEAT_W      = $clog2(EVENT_BEATS);
    localparam logic [BEAT_W-1:0] BEAT_HEADER = BEAT_W'(0);
    localparam logic [BEAT_W-1:0] BEAT_DX     = BEAT_W'(1);
    localparam logic [BEAT_W-1:0] BEAT_DY     = BEAT_W'(2);
    localparam logic [BEAT_W-1:0] BEAT_LAST   = BEAT_W'(EVENT_BEATS - 1);

    // input operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    // result kinds
    localparam logic KIND_EVENT  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // packet parser phase
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DX     = 2'd1,
        PH_DY     = 2'd2
    } phase_t;

    // byte constants of the mouse protocol
    localparam logic [7:0] HDR_SYNC_MASK = 8'hc0;
    localparam logic [7:0] DELTA_MIN     = 8'h80;
    localparam logic [7:0] DELTA_CLAMP   = 8'h81;
    localparam logic [7:0] EVT_MARK      = 8'h80;
    localparam logic [7:0] MOTION_POS    = 8'h7f;
    localparam logic [7:0] MOTION_NEG    = 8'h81;

    // one queued command: event record fields or a finished report
    //   event:  byte_a = record byte 0, byte_b = dx, byte_c = dy
    //   report: byte_a = status, byte_b = x motion, byte_c = y motion
    typedef struct packed {
        logic       kind;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] byte_c;
    } cmd_t;

    // a -128 delta is taken as -127
    function automatic logic [7:0] delta_of(input logic [7:0] b);
        delta_of = (b == DELTA_MIN) ? DELTA_CLAMP : b;
    endfunction

endpackage

/* rtl/core/ps2md_front.sv */
module ps2md_front #(
    parameter int ACC_WIDTH = ps2md_pkg::ACC_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  logic [7:0]        s_data_byte,
    input  logic              q_full,
    output logic              q_wr_en,
    output ps2md_pkg::cmd_t   q_wr_data
);

    localparam logic signed [ACC_WIDTH-1:0] POS_LIMIT = ACC_WIDTH'(127);
    localparam logic signed [ACC_WIDTH-1:0] NEG_LIMIT = -ACC_WIDTH'(127);
    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX =
        {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN =
        {1'b1, {(ACC_WIDTH-1){1'b0}}};

    logic                        port_open_reg;
    ps2md_pkg::phase_t           phase_reg, phase_next;
    logic [7:0]                  header_reg, header_next;
    logic [7:0]                  held_dx_reg, held_dx_next;
    logic [5:0]                  btn_status_reg, btn_status_next;
    logic signed [ACC_WIDTH-1:0] x_accum_reg, x_accum_next;
    logic signed [ACC_WIDTH-1:0] y_accum_reg, y_accum_next;

    logic                        accept;
    logic [7:0]                  dy;
    logic [2:0]                  btn;
    logic [2:0]                  chg;
    logic                        has_event;
    logic signed [ACC_WIDTH:0]   x_sum, y_sum;
    logic signed [ACC_WIDTH-1:0] x_sat, y_sat;
    logic [7:0]                  x_clamp, y_clamp;
    logic [6:0]                  report_status;

    // one command slot must be free before any beat is taken
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // packet decode
    assign dy        = ps2md_pkg::delta_of(s_data_byte);
    assign btn       = {header_reg[0], header_reg[2:1]};
    assign chg       = btn ^ btn_status_reg[2:0];
    assign has_event = (held_dx_reg != 8'd0) || (dy != 8'd0) || (chg != 3'd0);

    // saturating accumulate, overflow seen in the two top sum bits
    assign x_sum = {x_accum_reg[ACC_WIDTH-1], x_accum_reg}
                 + {{(ACC_WIDTH-7){held_dx_reg[7]}}, held_dx_reg};
    assign y_sum = {y_accum_reg[ACC_WIDTH-1], y_accum_reg}
                 + {{(ACC_WIDTH-7){dy[7]}}, dy};

    always_comb begin
        if (x_sum[ACC_WIDTH] != x_sum[ACC_WIDTH-1]) begin
            x_sat = x_sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        end else begin
            x_sat = x_sum[ACC_WIDTH-1:0];
        end
        if (y_sum[ACC_WIDTH] != y_sum[ACC_WIDTH-1]) begin
            y_sat = y_sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        end else begin
            y_sat = y_sum[ACC_WIDTH-1:0];
        end
    end

    // report motion clamped to +-127
    always_comb begin
        if (x_accum_reg > POS_LIMIT) begin
            x_clamp = ps2md_pkg::MOTION_POS;
        end else if (x_accum_reg < NEG_LIMIT) begin
            x_clamp = ps2md_pkg::MOTION_NEG;
        end else begin
            x_clamp = x_accum_reg[7:0];
        end
        if (y_accum_reg > POS_LIMIT) begin
            y_clamp = ps2md_pkg::MOTION_POS;
        end else if (y_accum_reg < NEG_LIMIT) begin
            y_clamp = ps2md_pkg::MOTION_NEG;
        end else begin
            y_clamp = y_accum_reg[7:0];
        end
    end

    assign report_status = {(x_accum_reg != '0) || (y_accum_reg != '0), btn_status_reg};

    // state update and command generation
    always_comb begin
        phase_next      = phase_reg;
        header_next     = header_reg;
        held_dx_next    = held_dx_reg;
        btn_status_next = btn_status_reg;
        x_accum_next    = x_accum_reg;
        y_accum_next    = y_accum_reg;
        q_wr_en         = 1'b0;
        q_wr_data       = '{kind:   ps2md_pkg::KIND_EVENT,
                            byte_a: ps2md_pkg::EVT_MARK | {5'd0, ~btn},
                            byte_b: held_dx_reg,
                            byte_c: dy};
        if (accept) begin
            if (s_operation == ps2md_pkg::OP_READ) begin
                q_wr_en         = 1'b1;
                q_wr_data       = '{kind:   ps2md_pkg::KIND_REPORT,
                                    byte_a: {1'b0, report_status},
                                    byte_b: x_clamp,
                                    byte_c: y_clamp};
                x_accum_next    = '0;
                y_accum_next    = '0;
                btn_status_next = {3'd0, btn_status_reg[2:0]};
            end else if (port_open_reg) begin
                case (phase_reg)
                    ps2md_pkg::PH_DX: begin
                        held_dx_next = ps2md_pkg::delta_of(s_data_byte);
                        phase_next   = ps2md_pkg::PH_DY;
                    end
                    ps2md_pkg::PH_DY: begin
                        phase_next      = ps2md_pkg::PH_HEADER;
                        btn_status_next = {btn_status_reg[5:3] | chg, btn};
                        if (has_event) begin
                            q_wr_en      = 1'b1;
                            x_accum_next = x_sat;
                            y_accum_next = y_sat;
                        end
                    end
                    default: begin
                        header_next = s_data_byte;
                        phase_next  = ((s_data_byte & ps2md_pkg::HDR_SYNC_MASK) == 8'd0)
                                    ? ps2md_pkg::PH_DX : ps2md_pkg::PH_HEADER;
                    end
                endcase
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_open_reg  <= 1'b0;
            phase_reg      <= ps2md_pkg::PH_HEADER;
            btn_status_reg <= '0;
            x_accum_reg    <= '0;
            y_accum_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                port_open_reg <= cfg_wr_data;
            end
            phase_reg      <= phase_next;
            btn_status_reg <= btn_status_next;
            x_accum_reg    <= x_accum_next;
            y_accum_reg    <= y_accum_next;
        end
    end

    // packet bytes, read only after being written
    always_ff @(posedge aclk) begin
        header_reg  <= header_next;
        held_dx_reg <= held_dx_next;
    end

endmodule

/* rtl/core/ps2md_queue.sv */
module ps2md_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  ps2md_pkg::cmd_t   wr_data,
    output logic              full,
    input  logic              rd_en,
    output ps2md_pkg::cmd_t   rd_data,
    output logic              empty
);

    ps2md_pkg::cmd_t                 slot_reg [ps2md_pkg::QUEUE_DEPTH];
    logic [ps2md_pkg::QPTR_W:0]      wr_ptr_reg, wr_ptr_next;
    logic [ps2md_pkg::QPTR_W:0]      rd_ptr_reg, rd_ptr_next;

    // pointers carry one wrap bit
    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[ps2md_pkg::QPTR_W] != rd_ptr_reg[ps2md_pkg::QPTR_W])
                && (wr_ptr_reg[ps2md_pkg::QPTR_W-1:0] == rd_ptr_reg[ps2md_pkg::QPTR_W-1:0]);
    assign rd_data = slot_reg[rd_ptr_reg[ps2md_pkg::QPTR_W-1:0]];

    assign wr_ptr_next = wr_ptr_reg + (ps2md_pkg::QPTR_W+1)'(wr_en && !full);
    assign rd_ptr_next = rd_ptr_reg + (ps2md_pkg::QPTR_W+1)'(rd_en && !empty);

    // pointer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (wr_en && !full) begin
            slot_reg[wr_ptr_reg[ps2md_pkg::QPTR_W-1:0]] <= wr_data;
        end
    end

endmodule

/* rtl/core/ps2md_back.sv */
module ps2md_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_empty,
    input  ps2md_pkg::cmd_t         q_rd_data,
    output logic                    q_rd_en,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_kind,
    output logic [7:0]              m_event_byte,
    output logic                    m_last,
    output logic [6:0]              m_status,
    output logic signed [7:0]       m_x_motion,
    output logic signed [7:0]       m_y_motion
);

    logic                             valid_reg, valid_next;
    ps2md_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [ps2md_pkg::BEAT_W-1:0]     beat_reg, beat_next;
    logic                             is_report;
    logic                             done;

    assign is_report = (cmd_reg.kind == ps2md_pkg::KIND_REPORT);
    assign m_last    = is_report || (beat_reg == ps2md_pkg::BEAT_LAST);
    assign done      = !valid_reg || (m_ready && m_last);
    assign q_rd_en   = done && !q_empty;

    // beat sequencing: next command loads as the last beat leaves
    always_comb begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        beat_next  = beat_reg;
        if (done) begin
            valid_next = !q_empty;
            cmd_next   = q_rd_data;
            beat_next  = ps2md_pkg::BEAT_HEADER;
        end else if (m_ready) begin
            beat_next = beat_reg + ps2md_pkg::BEAT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            beat_reg  <= ps2md_pkg::BEAT_HEADER;
        end else begin
            valid_reg <= valid_next;
            beat_reg  <= beat_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
    end

    // output fields of the current beat
    always_comb begin
        m_event_byte = 8'd0;
        if (!is_report) begin
            case (beat_reg)
                ps2md_pkg::BEAT_HEADER: m_event_byte = cmd_reg.byte_a;
                ps2md_pkg::BEAT_DX:     m_event_byte = cmd_reg.byte_b;
                ps2md_pkg::BEAT_DY:     m_event_byte = cmd_reg.byte_c;
                default:                m_event_byte = 8'd0;
            endcase
        end
    end

    assign m_valid    = valid_reg;
    assign m_kind     = cmd_reg.kind;
    assign m_status   = is_report ? cmd_reg.byte_a[6:0] : 7'd0;
    assign m_x_motion = is_report ? cmd_reg.byte_b : 8'sd0;
    assign m_y_motion = is_report ? cmd_reg.byte_c : 8'sd0;

endmodule

/* rtl/core/ps2_mouse_packet_decoder.sv */
// PS/2 mouse packet decoder. Mouse bytes (s_operation 0) are parsed into
// 3-byte packets while port_open, written through cfg_wr_en / cfg_wr_data,
// is set; otherwise they are dropped. A header is taken only when bits 7:6
// are zero. A completed packet with motion or a button change updates the
// saturating ACC_WIDTH-bit x/y accumulators and yields a 5-beat event
// record (m_kind 0, m_last on the fifth beat). A read (s_operation 1) is
// served whether or not the port is open and yields one report beat with
// status and motion clamped to +-127, then clears the accumulators and the
// change flags. An input beat is taken every cycle while the 4-entry command
// queue between parser and output sequencer has room; the output sequencer
// sends one beat per cycle while m_ready is high, so an event record gives 5
// output beats and every other item 1 or none.
module ps2_mouse_packet_decoder #(
    parameter int ACC_WIDTH = ps2md_pkg::ACC_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  logic [7:0]        s_data_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_kind,
    output logic [7:0]        m_event_byte,
    output logic              m_last,
    output logic [6:0]        m_status,
    output logic signed [7:0] m_x_motion,
    output logic signed [7:0] m_y_motion
);

    logic            q_wr_en;
    ps2md_pkg::cmd_t q_wr_data;
    logic            q_full;
    logic            q_rd_en;
    ps2md_pkg::cmd_t q_rd_data;
    logic            q_empty;

    // parser and accumulators
    ps2md_front #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_data_byte (s_data_byte),
        .q_full      (q_full),
        .q_wr_en     (q_wr_en),
        .q_wr_data   (q_wr_data)
    );

    // command queue
    ps2md_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // output beat sequencer
    ps2md_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_rd_data    (q_rd_data),
        .q_rd_en      (q_rd_en),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_event_byte (m_event_byte),
        .m_last       (m_last),
        .m_status     (m_status),
        .m_x_motion   (m_x_motion),
        .m_y_motion   (m_y_motion)
    );

endmodule

/* tb/sv/ps2_mouse_packet_decoder_tb.sv */
`timescale 1ns / 1ps

import ps2md_pkg::*;

// one beat on the result channel
typedef struct packed {
    logic       kind;
    logic [7:0] event_byte;
    logic       last;
    logic [6:0] status;
    logic [7:0] x_motion;
    logic [7:0] y_motion;
} mouse_beat_t;

// packet parser and motion accumulator mirror, with the queue of beats still owed
class mouse_scoreboard #(int ACC_W = 16);
    bit                      port_open;
    phase_t                  parse_phase;
    logic [7:0]              header_byte;
    logic [7:0]              held_dx;
    logic [5:0]              button_state;
    logic signed [ACC_W-1:0] x_accum;
    logic signed [ACC_W-1:0] y_accum;
    mouse_beat_t             owed_beats[$];
    int                      errors;

    function new();
        port_open    = 1'b0;
        parse_phase  = PH_HEADER;
        header_byte  = '0;
        held_dx      = '0;
        button_state = '0;
        x_accum      = '0;
        y_accum      = '0;
        errors       = 0;
    endfunction

    // a -128 delta counts as -127
    function logic [7:0] clamp_delta(logic [7:0] b);
        return (b == DELTA_MIN) ? DELTA_CLAMP : b;
    endfunction

    function logic signed [ACC_W-1:0] sat_accum(logic signed [ACC_W-1:0] acc,
                                                logic signed [7:0] d);
        longint sum;
        longint hi;
        hi  = (longint'(1) << (ACC_W - 1)) - 1;
        sum = longint'(acc) + longint'(d);
        if (sum > hi) begin
            sum = hi;
        end else if (sum < -hi - 1) begin
            sum = -hi - 1;
        end
        return sum[ACC_W-1:0];
    endfunction

    function logic [7:0] clamp_motion(logic signed [ACC_W-1:0] v);
        if (v > 127) begin
            return MOTION_POS;
        end
        if (v < -127) begin
            return MOTION_NEG;
        end
        return v[7:0];
    endfunction

    function int pending();
        return owed_beats.size();
    endfunction

    // accepted input beat: advance the parser and queue the beats it causes
    function void note_input(logic op, logic [7:0] b);
        mouse_beat_t      beat;
        logic [2:0]       btns;
        logic [2:0]       chg;
        logic signed [7:0] dx;
        logic signed [7:0] dy;

        // read report, served whether the port is open or not
        if (op == OP_READ) begin
            beat            = '0;
            beat.kind       = KIND_REPORT;
            beat.last       = 1'b1;
            beat.status     = {(x_accum != 0) || (y_accum != 0), button_state};
            beat.x_motion   = clamp_motion(x_accum);
            beat.y_motion   = clamp_motion(y_accum);
            owed_beats.push_back(beat);
            x_accum         = '0;
            y_accum         = '0;
            button_state[5:3] = 3'b000;
            return;
        end

        if (!port_open) begin
            return;
        end

        case (parse_phase)
            PH_DX: begin
                held_dx     = clamp_delta(b);
                parse_phase = PH_DY;
            end
            PH_DY: begin
                parse_phase  = PH_HEADER;
                dx           = held_dx;
                dy           = clamp_delta(b);
                // buttons as left, middle, right in bits 2:0
                btns         = {header_byte[0], header_byte[2:1]};
                chg          = btns ^ button_state[2:0];
                button_state = {button_state[5:3] | chg, btns};
                if (dx == 0 && dy == 0 && chg == 3'b000) begin
                    return;
                end
                x_accum = sat_accum(x_accum, dx);
                y_accum = sat_accum(y_accum, dy);
                for (int k = 0; k < EVENT_BEATS; k++) begin
                    beat      = '0;
                    beat.kind = KIND_EVENT;
                    beat.last = (k == EVENT_BEATS - 1);
                    if (k == 0) begin
                        beat.event_byte = EVT_MARK | {5'b00000, ~btns};
                    end else if (k == 1) begin
                        beat.event_byte = dx;
                    end else if (k == 2) begin
                        beat.event_byte = dy;
                    end
                    owed_beats.push_back(beat);
                end
            end
            default: begin
                // header: kept always, taken only with bits 7:6 clear
                header_byte = b;
                if ((b & HDR_SYNC_MASK) == 8'h00) begin
                    parse_phase = PH_DX;
                end else begin
                    parse_phase = PH_HEADER;
                end
            end
        endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
            errors++;
        end
    endfunction

    // accepted result beat against the oldest one owed
    function void check_result(mouse_beat_t got);
        mouse_beat_t want;
        if (owed_beats.size() == 0) begin
            $display("%0t: result beat with none expected, actual kind %0d byte %02h",
                     $time, got.kind, got.event_byte);
            errors++;
            return;
        end
        want = owed_beats.pop_front();
        compare_field("kind", want.kind, got.kind);
        compare_field("event_byte", want.event_byte, got.event_byte);
        compare_field("last", want.last, got.last);
        compare_field("status", want.status, got.status);
        compare_field("x_motion", want.x_motion, got.x_motion);
        compare_field("y_motion", want.y_motion, got.y_motion);
    endfunction
endclass

module ps2_mouse_packet_decoder_tb;

    // narrow accumulators so saturation comes within a few packets
    localparam int ACC_W         = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 16;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic              cfg_wr_data;
    logic              s_valid;
    logic              s_ready;
    logic              s_operation;
    logic [7:0]        s_data_byte;
    logic              m_valid;
    logic              m_ready;
    logic              m_kind;
    logic [7:0]        m_event_byte;
    logic              m_last;
    logic [6:0]        m_status;
    logic signed [7:0] m_x_motion;
    logic signed [7:0] m_y_motion;

    mouse_scoreboard #(ACC_W) sb;
    mouse_beat_t seen_beat;
    int          cycle_count;
    int          burst_left;
    bit          hold_req;
    logic [7:0]  last_hdr;

    ps2_mouse_packet_decoder #(
        .ACC_WIDTH(ACC_W)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_event_byte (m_event_byte),
        .m_last       (m_last),
        .m_status     (m_status),
        .m_x_motion   (m_x_motion),
        .m_y_motion   (m_y_motion)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // monitor: config writes, accepted input beats and result beats
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) begin
                sb.port_open = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                sb.note_input(s_operation, s_data_byte);
            end
            if (m_valid && m_ready) begin
                seen_beat.kind       = m_kind;
                seen_beat.event_byte = m_event_byte;
                seen_beat.last       = m_last;
                seen_beat.status     = m_status;
                seen_beat.x_motion   = m_x_motion;
                seen_beat.y_motion   = m_y_motion;
                sb.check_result(seen_beat);
            end
        end
    end

    // receiver: stall pattern drawn anew at random, long hold on request
    initial begin
        int rx_cycle;
        int rx_mode;
        rx_cycle = 0;
        rx_mode  = 0;
        m_ready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                rx_cycle++;
                if (rx_cycle % 48 == 0) begin
                    rx_mode = $urandom_range(0, 3);
                end
                case (rx_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 99) < 70);
                    2: m_ready <= ((rx_cycle % 7) < 4);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // offer one beat in bursts with random gaps, return once it is taken
    task automatic send_item(logic op, logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_operation <= op;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop offering until every owed beat has come, then let the block settle
    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_port_open(logic v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] pick_delta(int bias);
        if (bias > 0) begin
            return ($urandom_range(0, 3) == 0) ? MOTION_POS : 8'($urandom_range(96, 127));
        end
        if (bias < 0) begin
            return ($urandom_range(0, 3) == 0) ? DELTA_MIN : 8'($urandom_range(128, 160));
        end
        case ($urandom_range(0, 7))
            0: return DELTA_MIN;
            1: return MOTION_POS;
            2: return MOTION_NEG;
            3: return 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_packet(logic [7:0] hdr, logic [7:0] dx, logic [7:0] dy);
        send_item(OP_BYTE, hdr);
        send_item(OP_BYTE, dx);
        send_item(OP_BYTE, dy);
    endtask

    // mostly well-formed packets, with reads, stray bytes and cut-off packets
    task automatic random_stream(int n_items, int read_pct, int bias);
        int         sent;
        int         r;
        logic [7:0] hdr;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < read_pct) begin
                send_item(OP_READ, 8'($urandom_range(0, 255)));
                sent++;
            end else if (r < read_pct + 6) begin
                send_item(OP_BYTE, 8'($urandom_range(0, 255)));
                sent++;
            end else if (r < read_pct + 10) begin
                // header and dx only, the next byte lands in the dy slot
                send_item(OP_BYTE, {2'b00, 6'($urandom_range(0, 63))});
                send_item(OP_BYTE, pick_delta(bias));
                sent += 2;
            end else if (r < read_pct + 16) begin
                // same buttons, no motion
                send_packet(last_hdr, 8'h00, 8'h00);
                sent += 3;
            end else begin
                hdr      = {2'b00, 6'($urandom_range(0, 63))};
                last_hdr = hdr;
                send_packet(hdr, pick_delta(bias), pick_delta(bias));
                sent += 3;
            end
        end
    endtask

    // main sequence
    initial begin
        sb          = new();
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        s_valid     = 1'b0;
        s_operation = OP_BYTE;
        s_data_byte = 8'h00;
        burst_left  = 0;
        hold_req    = 1'b0;
        last_hdr    = 8'h00;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // read right after reset, then a byte while the port is still closed
        send_item(OP_READ, 8'hff);
        send_item(OP_BYTE, 8'h08);
        wait_for_drain();
        write_port_open(1'b1);

        // bad headers resync, then extreme deltas including -128
        send_item(OP_BYTE, 8'hc0);
        send_item(OP_BYTE, 8'h40);
        send_item(OP_BYTE, 8'h80);
        send_packet(8'h09, 8'h80, 8'h7f);
        send_packet(8'h06, 8'h7f, 8'h80);
        // unchanged buttons and no motion: no event
        send_packet(8'h06, 8'h00, 8'h00);
        send_item(OP_READ, 8'h00);
        send_packet(8'h3f, 8'hff, 8'h01);
        send_packet(8'h00, 8'h7f, 8'h7f);
        send_packet(8'h00, 8'h7f, 8'h7f);
        send_item(OP_READ, 8'h5a);
        wait_for_drain();

        random_stream(75, 10, 0);

        // long receiver hold while packets keep coming, so the input stalls
        hold_req = 1'b1;
        random_stream(60, 0, 1);
        wait_for_drain();

        // closed port: bytes dropped, reads still served
        write_port_open(1'b0);
        random_stream(25, 20, 0);
        wait_for_drain();
        write_port_open(1'b1);

        // drive the accumulators into both saturation limits
        random_stream(60, 4, 1);
        random_stream(60, 4, -1);
        random_stream(60, 15, 0);
        send_item(OP_READ, 8'h00);

        wait_for_drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/ps2md_pkg.sv
rtl/core/ps2md_front.sv
rtl/core/ps2md_queue.sv
rtl/core/ps2md_back.sv
rtl/core/ps2_mouse_packet_decoder.sv
tb/sv/ps2_mouse_packet_decoder_tb.sv
